// File: src/tzbq_pkg.sv
// shared types and constants for the touch zone button qualifier
// item structs, the classified command passed front to back, register codes
// no dependencies
`default_nettype none

package tzbq_pkg;

  localparam int unsigned NUM_BUTTONS     = 4;
  localparam int unsigned NUM_TOUCH_ZONES = 3;
  localparam int unsigned BTN_W           = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int unsigned LIFT_COUNT      =
    (NUM_TOUCH_ZONES < NUM_BUTTONS) ? NUM_TOUCH_ZONES : NUM_BUTTONS;

  // command queue between front and back
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // register map
  localparam int unsigned PADDR_W = 4;
  localparam logic [1:0] REG_HOLD_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_ZONE_ROW_MIN_Y = 2'd1;
  localparam logic [1:0] REG_SPLIT_AB_X     = 2'd2;
  localparam logic [1:0] REG_SPLIT_BC_X     = 2'd3;

  localparam logic [31:0]        HOLD_THRESHOLD_RST = 32'd1000;
  localparam logic signed [15:0] ZONE_ROW_MIN_Y_RST = 16'sd200;
  localparam logic signed [15:0] SPLIT_AB_X_RST     = 16'sd107;
  localparam logic signed [15:0] SPLIT_BC_X_RST     = 16'sd214;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [1:0] ZONE_NONE = 2'd0;
  localparam logic [1:0] ZONE_A    = 2'd1;
  localparam logic [1:0] ZONE_B    = 2'd2;
  localparam logic [1:0] ZONE_C    = 2'd3;

  typedef struct packed {
    logic               op;
    logic signed [15:0] touch_x;
    logic signed [15:0] touch_y;
    logic               touch_active;
    logic               touch_lifted;
    logic [31:0]        now_ms;
    logic [2:0]         button_sel;
    logic               clear_pressed;
    logic               clear_released;
  } sample_t;

  typedef struct packed {
    logic [1:0] zone_hit;
    logic       haptic_pulse;
    logic       level_pressed;
    logic       level_held;
    logic       pressed_event;
    logic       released_event;
  } result_t;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_TOUCH,
    KIND_LIFT,
    KIND_QUERY
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [1:0]       zone;
    logic             btn_ok;
    logic [BTN_W-1:0] btn;
    logic [31:0]      now_ms;
    logic             clear_pressed;
    logic             clear_released;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/touch_zone_button_qualifier_unit.sv
// an accepted request passes through the command queue and then the result register
// throughput: one request per cycle while sample_stall is low; a two-entry command queue parts front and back
// sample_stall rises only while the queue is full behind a stalled result register
// reset (rst, synchronous): all buttons released, flags cleared, registers to defaults
// depends on tzbq_pkg, tzbq_front, tzbq_queue, tzbq_back
`default_nettype none

module touch_zone_button_qualifier_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             sample_valid,
  output logic                                  sample_stall,
  input  wire tzbq_pkg::sample_t                sample,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output tzbq_pkg::result_t                     result,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [tzbq_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [31:0]                      pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  logic [31:0]        hold_limit_ms;
  logic signed [15:0] zone_row_min_y;
  logic signed [15:0] split_ab_x;
  logic signed [15:0] split_bc_x;
  logic [1:0]         reg_idx;
  logic               reg_wr;

  logic               q_full;
  logic               q_push;
  tzbq_pkg::cmd_t     q_cmd;
  logic               q_pop;
  tzbq_pkg::cmd_t     q_head;
  logic               q_nonempty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_limit_ms  <= tzbq_pkg::HOLD_THRESHOLD_RST;
      zone_row_min_y <= tzbq_pkg::ZONE_ROW_MIN_Y_RST;
      split_ab_x     <= tzbq_pkg::SPLIT_AB_X_RST;
      split_bc_x     <= tzbq_pkg::SPLIT_BC_X_RST;
    end else if (reg_wr) begin
      case (reg_idx)
        tzbq_pkg::REG_HOLD_THRESHOLD: hold_limit_ms  <= pwdata;
        tzbq_pkg::REG_ZONE_ROW_MIN_Y: zone_row_min_y <= pwdata[15:0];
        tzbq_pkg::REG_SPLIT_AB_X:     split_ab_x     <= pwdata[15:0];
        tzbq_pkg::REG_SPLIT_BC_X:     split_bc_x     <= pwdata[15:0];
        default:                      hold_limit_ms  <= hold_limit_ms;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tzbq_pkg::REG_HOLD_THRESHOLD: prdata = hold_limit_ms;
      tzbq_pkg::REG_ZONE_ROW_MIN_Y: prdata = 32'(zone_row_min_y);
      tzbq_pkg::REG_SPLIT_AB_X:     prdata = 32'(split_ab_x);
      tzbq_pkg::REG_SPLIT_BC_X:     prdata = 32'(split_bc_x);
      default:                      prdata = '0;
    endcase
  end

  tzbq_front u_front (
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample         (sample),
    .zone_row_min_y (zone_row_min_y),
    .split_ab_x     (split_ab_x),
    .split_bc_x     (split_bc_x),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  tzbq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .nonempty (q_nonempty)
  );

  tzbq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .hold_limit_ms (hold_limit_ms),
    .q_nonempty    (q_nonempty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

endmodule

`default_nettype wire

// File: src/tzbq_front.sv
// front end: takes sample requests and classifies them into commands
// zone lookup against the row limit and split points, button decode
// depends on tzbq_pkg
`default_nettype none

module tzbq_front (
  input  wire logic                    sample_valid,
  output logic                         sample_stall,
  input  wire tzbq_pkg::sample_t       sample,
  input  wire logic signed [15:0]      zone_row_min_y,
  input  wire logic signed [15:0]      split_ab_x,
  input  wire logic signed [15:0]      split_bc_x,
  input  wire logic                    q_full,
  output logic                         q_push,
  output tzbq_pkg::cmd_t               q_cmd
);

  logic [1:0] zone;
  logic [4:0] nb;

  assign nb = 5'(tzbq_pkg::NUM_BUTTONS);

  always_comb begin
    if ($signed(sample.touch_y) < zone_row_min_y) begin
      zone = tzbq_pkg::ZONE_NONE;
    end else if ($signed(sample.touch_x) < split_ab_x) begin
      zone = tzbq_pkg::ZONE_A;
    end else if ($signed(sample.touch_x) < split_bc_x) begin
      zone = tzbq_pkg::ZONE_B;
    end else begin
      zone = tzbq_pkg::ZONE_C;
    end
  end

  always_comb begin
    q_cmd.kind           = tzbq_pkg::KIND_NOP;
    q_cmd.zone           = tzbq_pkg::ZONE_NONE;
    q_cmd.btn_ok         = 1'b0;
    q_cmd.btn            = '0;
    q_cmd.now_ms         = sample.now_ms;
    q_cmd.clear_pressed  = sample.clear_pressed;
    q_cmd.clear_released = sample.clear_released;
    if (sample.op == tzbq_pkg::OP_QUERY) begin
      q_cmd.kind   = tzbq_pkg::KIND_QUERY;
      q_cmd.btn_ok = (sample.button_sel != 3'd0) && ({2'b00, sample.button_sel} <= nb);
      q_cmd.btn    = tzbq_pkg::BTN_W'(sample.button_sel - 3'd1);
    end else if (sample.touch_active) begin
      // an active touch wins over a lift on the same sample
      q_cmd.kind   = tzbq_pkg::KIND_TOUCH;
      q_cmd.zone   = zone;
      q_cmd.btn_ok = (zone != tzbq_pkg::ZONE_NONE) && ({3'b000, zone} <= nb);
      q_cmd.btn    = tzbq_pkg::BTN_W'(zone - 2'd1);
    end else if (sample.touch_lifted) begin
      q_cmd.kind   = tzbq_pkg::KIND_LIFT;
    end
  end

  assign sample_stall = q_full;
  assign q_push       = sample_valid && !q_full;

endmodule

`default_nettype wire

// File: src/tzbq_queue.sv
// short command queue that decouples the front end from the button engine
// depends on tzbq_pkg
`default_nettype none

module tzbq_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tzbq_pkg::cmd_t  push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output tzbq_pkg::cmd_t       head,
  output logic                 nonempty
);

  tzbq_pkg::cmd_t                  slots [tzbq_pkg::QDEPTH];
  logic [tzbq_pkg::QPTR_W-1:0]     wr_ptr;
  logic [tzbq_pkg::QPTR_W-1:0]     rd_ptr;
  logic [tzbq_pkg::QCNT_W-1:0]     count;
  logic [tzbq_pkg::QPTR_W-1:0]     wr_ptr_next;
  logic [tzbq_pkg::QPTR_W-1:0]     rd_ptr_next;

  localparam logic [tzbq_pkg::QPTR_W-1:0] LAST_SLOT = tzbq_pkg::QPTR_W'(tzbq_pkg::QDEPTH - 1);
  localparam logic [tzbq_pkg::QCNT_W-1:0] DEPTH_CNT = tzbq_pkg::QCNT_W'(tzbq_pkg::QDEPTH);

  assign full     = (count == DEPTH_CNT);
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  assign wr_ptr_next = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_push_grows : assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on a lone push");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

// File: src/tzbq_back.sv
// back end: per-button press/hold/release engine and the result register
// depends on tzbq_pkg
`default_nettype none

module tzbq_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [31:0]         hold_limit_ms,
  input  wire logic                q_nonempty,
  input  wire tzbq_pkg::cmd_t      q_head,
  output logic                     q_pop,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output tzbq_pkg::result_t        result
);

  typedef enum logic [1:0] {
    MODE_RELEASED,
    MODE_PRESSED,
    MODE_HELD
  } mode_t;

  mode_t       mode          [tzbq_pkg::NUM_BUTTONS];
  logic        press_latch   [tzbq_pkg::NUM_BUTTONS];
  logic        release_latch [tzbq_pkg::NUM_BUTTONS];
  logic [31:0] start_ms      [tzbq_pkg::NUM_BUTTONS];

  tzbq_pkg::cmd_t    cmd;
  tzbq_pkg::result_t result_next;
  mode_t             cur_mode;
  logic [31:0]       elapsed;
  logic              hold_due;

  assign cmd      = q_head;
  assign q_pop    = q_nonempty && (!result_valid || !result_stall);
  assign cur_mode = mode[cmd.btn];
  assign elapsed  = cmd.now_ms - start_ms[cmd.btn];
  assign hold_due = (elapsed >= hold_limit_ms);

  always_comb begin
    result_next = '0;
    case (cmd.kind)
      tzbq_pkg::KIND_TOUCH: begin
        result_next.zone_hit     = cmd.zone;
        result_next.haptic_pulse = cmd.btn_ok && (cur_mode == MODE_RELEASED);
      end
      tzbq_pkg::KIND_QUERY: begin
        if (cmd.btn_ok) begin
          result_next.level_pressed  = (cur_mode == MODE_PRESSED) || (cur_mode == MODE_HELD);
          result_next.level_held     = (cur_mode == MODE_HELD);
          result_next.pressed_event  = press_latch[cmd.btn];
          result_next.released_event = release_latch[cmd.btn];
        end
      end
      default: result_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tzbq_pkg::NUM_BUTTONS; i++) begin
        mode[i]          <= MODE_RELEASED;
        press_latch[i]   <= 1'b0;
        release_latch[i] <= 1'b0;
      end
      result_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        result       <= result_next;
        result_valid <= 1'b1;
        case (cmd.kind)
          tzbq_pkg::KIND_TOUCH: begin
            if (cmd.btn_ok) begin
              case (cur_mode)
                MODE_RELEASED: begin
                  mode[cmd.btn]        <= MODE_PRESSED;
                  press_latch[cmd.btn] <= 1'b1;
                  start_ms[cmd.btn]    <= cmd.now_ms;
                end
                MODE_PRESSED: begin
                  if (hold_due) begin
                    mode[cmd.btn] <= MODE_HELD;
                  end
                end
                default: mode[cmd.btn] <= cur_mode;
              endcase
            end
          end
          tzbq_pkg::KIND_LIFT: begin
            // a lift only reaches the buttons that have a touch zone
            for (int i = 0; i < tzbq_pkg::LIFT_COUNT; i++) begin
              if (mode[i] != MODE_RELEASED) begin
                mode[i]          <= MODE_RELEASED;
                release_latch[i] <= 1'b1;
              end
            end
          end
          tzbq_pkg::KIND_QUERY: begin
            if (cmd.btn_ok) begin
              if (cmd.clear_pressed) begin
                press_latch[cmd.btn] <= 1'b0;
              end
              if (cmd.clear_released) begin
                release_latch[cmd.btn] <= 1'b0;
              end
            end
          end
          default: ;
        endcase
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_lift_releases : assert property (@(posedge clk) disable iff (rst)
    q_pop && cmd.kind == tzbq_pkg::KIND_LIFT |=> mode[0] == MODE_RELEASED)
    else $error("first button still down after a lift");

  a_new_press_haptic : assert property (@(posedge clk) disable iff (rst)
    q_pop && cmd.kind == tzbq_pkg::KIND_TOUCH && cmd.btn_ok && cur_mode == MODE_RELEASED
    |=> result_valid && result.haptic_pulse && mode[$past(cmd.btn)] == MODE_PRESSED)
    else $error("new press without haptic pulse or pressed mode");

  a_haptic_only_touch : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.haptic_pulse |-> !result.level_pressed && !result.pressed_event)
    else $error("haptic pulse on a query result");

endmodule

`default_nettype wire

// File: dv/tb_touch_zone_button_qualifier_unit.sv
`timescale 1ns / 100ps
// self-checking bench for touch_zone_button_qualifier_unit: directed and random touch and query
// requests, checked against an in-bench button tracker, with APB retuning between phases
// depends on tzbq_pkg and the unit under test
module tb_touch_zone_button_qualifier_unit;

  localparam int CLK_HALF    = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int CALM_FROM   = 1200;
  localparam int CALM_TO     = 1700;
  localparam int HOLDOFF_AT  = 600;
  localparam int HOLDOFF_LEN = 90;

  typedef enum logic [1:0] {BTN_UP, BTN_DOWN, BTN_HELD} btn_mode_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          sample_valid = 1'b0;
  logic                          sample_stall;
  tzbq_pkg::sample_t             sample = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  tzbq_pkg::result_t             result;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [tzbq_pkg::PADDR_W-1:0]  paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  touch_zone_button_qualifier_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // tracker copy of the registers and per-button state
  logic [31:0]        hold_ms = tzbq_pkg::HOLD_THRESHOLD_RST;
  logic signed [15:0] row_y   = tzbq_pkg::ZONE_ROW_MIN_Y_RST;
  logic signed [15:0] ab_x    = tzbq_pkg::SPLIT_AB_X_RST;
  logic signed [15:0] bc_x    = tzbq_pkg::SPLIT_BC_X_RST;
  btn_mode_t          btn_mode     [tzbq_pkg::NUM_BUTTONS] = '{default: BTN_UP};
  logic               press_flag   [tzbq_pkg::NUM_BUTTONS] = '{default: 1'b0};
  logic               release_flag [tzbq_pkg::NUM_BUTTONS] = '{default: 1'b0};
  logic [31:0]        press_t0     [tzbq_pkg::NUM_BUTTONS] = '{default: 32'd0};

  tzbq_pkg::sample_t touch_req_q[$];
  tzbq_pkg::result_t outcome_q[$];
  int          cyc = 0;
  int          n_fail = 0;
  int          n_queued = 0;
  int          n_taken = 0;
  int          n_results = 0;
  int          n_presses = 0;
  int          n_holds = 0;
  int          n_backpressure = 0;
  int          holdoff_left = 0;
  logic        holdoff_done = 1'b0;
  logic        sample_took = 1'b0;
  logic [31:0] clk_ms = 32'd0;

  function automatic tzbq_pkg::result_t qualify_request(input tzbq_pkg::sample_t s);
    tzbq_pkg::result_t r;
    logic [1:0]  z;
    int          b;
    logic [31:0] elapsed;
    r = '0;
    if (s.op == tzbq_pkg::OP_SAMPLE) begin
      if (s.touch_active) begin
        // an active touch wins over a lift on the same request
        if ($signed(s.touch_y) < row_y) z = tzbq_pkg::ZONE_NONE;
        else if ($signed(s.touch_x) < ab_x) z = tzbq_pkg::ZONE_A;
        else if ($signed(s.touch_x) < bc_x) z = tzbq_pkg::ZONE_B;
        else z = tzbq_pkg::ZONE_C;
        r.zone_hit = z;
        if (z != tzbq_pkg::ZONE_NONE) begin
          b = int'(z) - 1;
          if (btn_mode[b] == BTN_UP) begin
            btn_mode[b]   = BTN_DOWN;
            press_flag[b] = 1'b1;
            press_t0[b]   = s.now_ms;
            r.haptic_pulse = 1'b1;
            n_presses++;
          end else if (btn_mode[b] == BTN_DOWN) begin
            elapsed = s.now_ms - press_t0[b];
            if (elapsed >= hold_ms) begin
              btn_mode[b] = BTN_HELD;
              n_holds++;
            end
          end
        end
      end else if (s.touch_lifted) begin
        for (int i = 0; i < tzbq_pkg::LIFT_COUNT; i++) begin
          if (btn_mode[i] != BTN_UP) begin
            btn_mode[i]     = BTN_UP;
            release_flag[i] = 1'b1;
            press_t0[i]     = 32'd0;
          end
        end
      end
    end else if (s.button_sel != 0 && s.button_sel <= tzbq_pkg::NUM_BUTTONS) begin
      b = int'(s.button_sel) - 1;
      r.level_pressed  = (btn_mode[b] != BTN_UP);
      r.level_held     = (btn_mode[b] == BTN_HELD);
      r.pressed_event  = press_flag[b];
      r.released_event = release_flag[b];
      if (s.clear_pressed) press_flag[b] = 1'b0;
      if (s.clear_released) release_flag[b] = 1'b0;
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [1:0] want,
                                      input logic [1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // unused fields of every request carry random junk
  function automatic tzbq_pkg::sample_t junk_req();
    logic [95:0] junk;
    junk = {$urandom(), $urandom(), $urandom()};
    return junk[$bits(tzbq_pkg::sample_t)-1:0];
  endfunction

  task automatic push_req(input tzbq_pkg::sample_t s);
    touch_req_q.push_back(s);
    n_queued++;
  endtask

  task automatic add_touch(input int xi, input int yi, input logic act, input logic lift,
                           input logic [31:0] t);
    tzbq_pkg::sample_t s;
    s = junk_req();
    s.op           = tzbq_pkg::OP_SAMPLE;
    s.touch_x      = xi[15:0];
    s.touch_y      = yi[15:0];
    s.touch_active = act;
    s.touch_lifted = lift;
    s.now_ms       = t;
    push_req(s);
  endtask

  task automatic add_query(input logic [2:0] sel, input logic clr_p, input logic clr_r);
    tzbq_pkg::sample_t s;
    s = junk_req();
    s.op             = tzbq_pkg::OP_QUERY;
    s.button_sel     = sel;
    s.clear_pressed  = clr_p;
    s.clear_released = clr_r;
    push_req(s);
  endtask

  task automatic add_rand_query();
    logic [2:0] sel;
    sel = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    add_query(sel, $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  // press one zone, possibly touch it again around the hold time, then mostly lift, and query
  task automatic add_gesture();
    int          zone;
    int          n;
    int          xi;
    int          yi;
    logic [31:0] t0;
    logic [31:0] t;
    zone = $urandom_range(1, 3);
    n    = $urandom_range(1, 6);
    t0   = clk_ms;
    for (int k = 0; k < n; k++) begin
      case (zone)
        1: xi = ($urandom_range(0, 3) == 0) ? ab_x - 1 : ab_x - int'($urandom_range(1, 400));
        2: begin
          if (ab_x < bc_x && $urandom_range(0, 3) != 0)
            xi = ab_x + int'($urandom_range(0, int'(bc_x) - int'(ab_x) - 1));
          else
            xi = ($urandom_range(0, 1) == 0) ? ab_x : bc_x - 1;
        end
        default: xi = ($urandom_range(0, 3) == 0) ? bc_x : bc_x + int'($urandom_range(0, 400));
      endcase
      case ($urandom_range(0, 7))
        0: yi = row_y;
        1: yi = row_y - 1;
        default: yi = row_y + int'($urandom_range(1, 500));
      endcase
      case ($urandom_range(0, 3))
        0: t = t0 + hold_ms - 32'd1;
        1: t = t0 + hold_ms;
        2: t = t0 + 32'($urandom_range(0, 3000));
        default: t = t0 + $urandom();
      endcase
      if (k == 0) t = t0;
      add_touch(clamp16(xi), clamp16(yi), 1'b1, $urandom_range(0, 9) == 0, t);
      if ($urandom_range(0, 3) == 0) add_rand_query();
    end
    clk_ms = ($urandom_range(0, 9) == 0) ? $urandom() : t0 + 32'($urandom_range(0, 5000));
    if ($urandom_range(0, 4) != 0)
      add_touch(int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768,
                1'b0, 1'b1, clk_ms);
    repeat ($urandom_range(1, 3)) add_rand_query();
  endtask

  task automatic run_random(input int count);
    int goal;
    goal = n_queued + count;
    while (n_queued < goal) begin
      if ($urandom_range(0, 3) != 0) add_gesture();
      else repeat ($urandom_range(1, 3)) push_req(junk_req());
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      tzbq_pkg::REG_HOLD_THRESHOLD: hold_ms = val;
      tzbq_pkg::REG_ZONE_ROW_MIN_Y: row_y = val[15:0];
      tzbq_pkg::REG_SPLIT_AB_X:     ab_x = val[15:0];
      tzbq_pkg::REG_SPLIT_BC_X:     bc_x = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // upper halves of the 16-bit registers get junk, only the low half counts
  task automatic write_zones(input int r, input int a, input int c);
    write_reg(tzbq_pkg::REG_ZONE_ROW_MIN_Y, {16'($urandom()), r[15:0]});
    write_reg(tzbq_pkg::REG_SPLIT_AB_X, {16'($urandom()), a[15:0]});
    write_reg(tzbq_pkg::REG_SPLIT_BC_X, {16'($urandom()), c[15:0]});
  endtask

  task automatic wait_drained();
    while (touch_req_q.size() != 0 || sample_valid || outcome_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(negedge clk) begin : drive_req
    logic gap;
    gap = (cyc < CALM_FROM || cyc >= CALM_TO) && ($urandom_range(0, 99) < 38);
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || sample_took) begin
      if (touch_req_q.size() != 0 && !gap) begin
        sample       <= touch_req_q.pop_front();
        sample_valid <= 1'b1;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // result side: random stalls, one calm window and one long hold-off to fill the unit
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      result_stall <= 1'b1;
    end else if (!holdoff_done && n_taken >= HOLDOFF_AT) begin
      holdoff_done <= 1'b1;
      holdoff_left <= HOLDOFF_LEN;
      result_stall <= 1'b1;
    end else if (cyc >= CALM_FROM && cyc < CALM_TO) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < 38);
    end
  end

  always @(posedge clk) begin : watch
    tzbq_pkg::result_t want;
    if (rst) begin
      sample_took <= 1'b0;
    end else begin
      sample_took <= sample_valid && !sample_stall;
      if (sample_valid && sample_stall) n_backpressure++;
      if (result_valid && !result_stall) begin
        if (outcome_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          n_fail++;
        end else begin
          want = outcome_q.pop_front();
          check_field("zone_hit", want.zone_hit, result.zone_hit);
          check_field("haptic_pulse", want.haptic_pulse, result.haptic_pulse);
          check_field("level_pressed", want.level_pressed, result.level_pressed);
          check_field("level_held", want.level_held, result.level_held);
          check_field("pressed_event", want.pressed_event, result.pressed_event);
          check_field("released_event", want.released_event, result.released_event);
          n_results++;
        end
      end
      if (sample_valid && !sample_stall) begin
        outcome_q.push_back(qualify_request(sample));
        n_taken++;
      end
    end
  end

  initial begin
    // directed requests at reset register values
    add_query(3'd0, 1'b1, 1'b1);
    add_query(3'd1, 1'b0, 1'b0);
    add_query(3'd4, 1'b1, 1'b1);
    add_query(3'd5, 1'b1, 1'b1);
    add_query(3'd7, 1'b0, 1'b0);
    add_touch(-32768, 200, 1'b1, 1'b0, 32'd100);
    add_touch(106, 32767, 1'b1, 1'b0, 32'd1099);
    add_touch(0, 300, 1'b1, 1'b0, 32'd1100);
    add_touch(50, 250, 1'b1, 1'b0, 32'd1101);
    add_touch(107, 32767, 1'b1, 1'b1, 32'd5);
    add_touch(213, 199, 1'b1, 1'b0, 32'd6);
    add_touch(32767, 200, 1'b1, 1'b0, 32'hFFFF_FF00);
    // elapsed time wraps past zero here
    add_touch(214, 200, 1'b1, 1'b0, 32'd1000);
    add_touch(-32768, -32768, 1'b0, 1'b0, 32'hFFFF_FFFF);
    add_query(3'd1, 1'b0, 1'b0);
    add_query(3'd1, 1'b1, 1'b1);
    add_query(3'd1, 1'b0, 1'b0);
    add_query(3'd2, 1'b1, 1'b0);
    add_query(3'd4, 1'b0, 1'b0);
    add_touch(0, 0, 1'b0, 1'b1, 32'd0);
    add_query(3'd1, 1'b0, 1'b1);
    add_query(3'd2, 1'b0, 1'b1);
    add_query(3'd3, 1'b1, 1'b1);
    add_query(3'd3, 1'b0, 1'b0);
    add_touch(213, 200, 1'b1, 1'b0, 32'd40);
    run_random(260);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int p = 1; p <= 6; p++) begin
      wait_drained();
      case (p)
        1: begin
          write_reg(tzbq_pkg::REG_HOLD_THRESHOLD, 32'd0);
          write_zones(-32768, -32768, 32767);
        end
        2: begin
          write_reg(tzbq_pkg::REG_HOLD_THRESHOLD, 32'hFFFF_FFFF);
          write_zones(32767, 32767, -32768);
        end
        5: begin
          write_reg(tzbq_pkg::REG_HOLD_THRESHOLD, $urandom());
          write_zones(int'($urandom_range(0, 65535)) - 32768,
                      int'($urandom_range(0, 65535)) - 32768,
                      int'($urandom_range(0, 65535)) - 32768);
        end
        6: begin
          write_reg(tzbq_pkg::REG_HOLD_THRESHOLD, 32'd1);
          write_zones(-1, -100, 100);
        end
        default: begin : pick_zones
          int a;
          a = int'($urandom_range(0, 400)) - 200;
          write_reg(tzbq_pkg::REG_HOLD_THRESHOLD, $urandom_range(0, 2500));
          write_zones(int'($urandom_range(0, 600)) - 300, a, a + int'($urandom_range(0, 400)));
        end
      endcase
      run_random(220);
    end

    wait_drained();
    repeat (5) @(posedge clk);
    if (outcome_q.size() != 0) begin
      $error("%0d results never arrived", outcome_q.size());
      n_fail++;
    end
    $display("run: %0d requests in, %0d results checked over seven register settings",
             n_taken, n_results);
    $display("     %0d presses, %0d holds, input stalled on %0d cycles",
             n_presses, n_holds, n_backpressure);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
